// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RC4_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rc4 assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RC4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rc4 assertion failed");

`endif

// File: rtl/rc4_pkg.sv
// shared types, constants and helpers of the rc4 stream cipher
// no dependencies
package rc4_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KEY_BITS = 128;
	localparam int PERM_SIZE = 256;
	localparam int ADDR_W = $clog2(PERM_SIZE);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd2;

	localparam logic [4:0] KEY_LENGTH_RESET = 5'd4;
	localparam logic [ADDR_W-1:0] CNT_LAST = ADDR_W'(PERM_SIZE - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_KS_RD_A,
		ST_KS_RD_B,
		ST_KS_WR_A,
		ST_KS_WR_B,
		ST_PR_RD_I,
		ST_PR_RD_J,
		ST_PR_WR_I,
		ST_PR_WR_J,
		ST_PR_OUT
	} eng_state_t;

	// key material seen by the engine
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [KIDX_W-1:0]   len_m1;
	} key_cfg_t;

	// one write and one read access to the permutation memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [7:0] key_byte(logic [KEY_BITS-1:0] key, logic [KIDX_W-1:0] idx);
		key_byte = key[{idx, 3'b000} +: 8];
	endfunction

endpackage

// File: rtl/rc4_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read, read returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/rc4_engine.sv
// key schedule and keystream sequencer with its output register
// depends on rc4_pkg; drives the permutation memory through a ram_req_t
module rc4_engine import rc4_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_out,
	input  key_cfg_t    cfg,
	output ram_req_t    ram_req,
	input  logic [7:0]  ram_rdata
);

	eng_state_t        state_q, state_d;
	logic [ADDR_W-1:0] cnt_q;
	logic [KIDX_W-1:0] kidx_q;
	logic [7:0]        i_q, j_q;
	logic [7:0]        sa_q, sb_q;
	logic              hit_q;
	logic [7:0]        data_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;

	logic       out_free;
	logic [7:0] j_sched;
	logic [7:0] j_prga;
	logic [7:0] t_addr;
	logic [7:0] ks;

	assign out_free = !out_valid_q || out_ready;
	assign j_sched = j_q + ram_rdata + key_byte(cfg.key, kidx_q);
	assign j_prga = j_q + ram_rdata;
	assign t_addr = sa_q + sb_q;
	// the read of the sum entry overlaps the write of entry j
	assign ks = hit_q ? sa_q : ram_rdata;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = start_of_message ? ST_FILL : ST_PR_RD_I;
				end
			end
			ST_FILL: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_KS_RD_A;
				end
			end
			ST_KS_RD_A: state_d = ST_KS_RD_B;
			ST_KS_RD_B: state_d = ST_KS_WR_A;
			ST_KS_WR_A: state_d = ST_KS_WR_B;
			ST_KS_WR_B: state_d = (cnt_q == CNT_LAST) ? ST_PR_RD_I : ST_KS_RD_A;
			ST_PR_RD_I: state_d = ST_PR_RD_J;
			ST_PR_RD_J: state_d = ST_PR_WR_I;
			ST_PR_WR_I: state_d = ST_PR_WR_J;
			ST_PR_WR_J: state_d = ST_PR_OUT;
			ST_PR_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory accesses and handshake per state
	always_comb begin
		in_ready = 1'b0;
		ram_req = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_FILL: begin
				ram_req.we = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = 8'(cnt_q);
			end
			ST_KS_RD_A: ram_req.raddr = cnt_q;
			ST_KS_RD_B: ram_req.raddr = j_sched;
			ST_KS_WR_A: begin
				ram_req.we = 1'b1;
				ram_req.waddr = cnt_q;
				ram_req.wdata = ram_rdata;
			end
			ST_KS_WR_B: begin
				ram_req.we = 1'b1;
				ram_req.waddr = j_q;
				ram_req.wdata = sa_q;
			end
			ST_PR_RD_I: ram_req.raddr = i_q;
			ST_PR_RD_J: ram_req.raddr = j_prga;
			ST_PR_WR_I: begin
				ram_req.we = 1'b1;
				ram_req.waddr = i_q;
				ram_req.wdata = ram_rdata;
			end
			ST_PR_WR_J: begin
				ram_req.we = 1'b1;
				ram_req.waddr = j_q;
				ram_req.wdata = sa_q;
				ram_req.raddr = t_addr;
			end
			ST_PR_OUT: ram_req.raddr = t_addr;
			default: ram_req = '0;
		endcase
	end

	// control registers: state, indices, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			kidx_q <= '0;
			i_q <= '0;
			j_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// result word raised on leaving the output state, dropped once taken
			if (state_q == ST_PR_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (start_of_message) begin
							cnt_q <= '0;
							kidx_q <= '0;
							j_q <= '0;
						end else begin
							i_q <= i_q + 8'd1;
						end
					end
				end
				ST_FILL: cnt_q <= cnt_q + 1'b1;
				ST_KS_RD_B: j_q <= j_sched;
				ST_KS_WR_B: begin
					cnt_q <= cnt_q + 1'b1;
					kidx_q <= (kidx_q == cfg.len_m1) ? '0 : kidx_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						i_q <= 8'd1;
						j_q <= '0;
					end
				end
				ST_PR_RD_J: j_q <= j_prga;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			data_q <= data_byte;
		end
		if (state_q == ST_KS_RD_B || state_q == ST_PR_RD_J) begin
			sa_q <= ram_rdata;
		end
		if (state_q == ST_PR_WR_I) begin
			sb_q <= ram_rdata;
		end
		if (state_q == ST_PR_WR_J) begin
			hit_q <= (t_addr == j_q);
		end
		if (state_q == ST_PR_OUT && out_free) begin
			out_data_q <= data_q ^ ks;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out = out_data_q;

endmodule

// File: rtl/rc4_stream_cipher_top.sv
// rc4 stream cipher: an accepted data word passes the read, read, write, write, read
// sequence on the single permutation memory before its result is valid, and no new
// word is taken until that result is in the output register. a start-of-message word
// first fills the 256 memory entries and then runs the key schedule rounds. reset restores
// the key registers and clears both indices; the permutation is not cleared, so the first
// word must be a start of message. depends on rc4_pkg, rc4_ram and rc4_engine
module rc4_stream_cipher_top import rc4_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  start_of_message,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            data_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [4:0]            key_length_q;
	logic [CFG_DATA_W-1:0] key_low_q;
	logic [CFG_DATA_W-1:0] key_high_q;
	key_cfg_t              cfg;
	ram_req_t              ram_req;
	logic [7:0]            ram_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KEY_LENGTH_RESET;
			key_low_q <= '0;
			key_high_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_LENGTH: key_length_q <= cfg_data[4:0];
				CFG_KEY_LOW: key_low_q <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp key length to one through the maximum, kept as last key byte index
	always_comb begin
		cfg.key = {key_high_q, key_low_q};
		if (key_length_q == 5'd0) begin
			cfg.len_m1 = '0;
		end else if (key_length_q > 5'(MAX_KEY_BYTES)) begin
			cfg.len_m1 = KIDX_W'(MAX_KEY_BYTES - 1);
		end else begin
			cfg.len_m1 = KIDX_W'(key_length_q - 5'd1);
		end
	end

	rc4_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_out         (data_out),
		.cfg              (cfg),
		.ram_req          (ram_req),
		.ram_rdata        (ram_rdata)
	);

	// permutation memory
	rc4_ram #(
		.WIDTH (8),
		.DEPTH (PERM_SIZE)
	) u_perm (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

// File: rtl/rc4_checker.sv
// port-level assertions for the rc4 stream cipher, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rc4_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] data_out
);

	// a stalled result word holds
	`RC4_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(data_out))
	// an accepted word keeps the block busy at least through its keystream steps
	`RC4_ASSERT_NEXT(a_busy_next, clk, arst_n, in_valid && in_ready, !in_ready)
	`RC4_ASSERT_IMPL(a_busy_later, clk, arst_n, in_valid && in_ready, ##5 !in_ready)
	// a new result appears only right after a busy cycle
	`RC4_ASSERT_IMPL(a_out_after_busy, clk, arst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_out  (data_out)
);

// File: test/tb_rc4_stream_cipher_top.sv
`timescale 1ns / 100ps
// self-checking bench for rc4_stream_cipher_top: directed known-answer words, then
// random keys and messages checked against an in-bench rc4 predictor
// depends on rc4_pkg and the rc4_stream_cipher_top rtl
module tb_rc4_stream_cipher_top;
	import rc4_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int ITEM_TARGET = 1250;
	localparam int CALM_ITEMS = 150;
	localparam int LONG_MSG = 520;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 8000000;
	localparam int MAX_REPORTS = 100;
	// index past the last register, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		logic [7:0]            din;
		logic                  som;
		logic                  known;
		logic [7:0]            known_out;
	} stim_row_t;

	typedef struct {
		logic [7:0] data_out;
		int         seq;
	} cipher_exp_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            data_byte;
	logic                  start_of_message;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            data_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic [7:0]            sbox [PERM_SIZE];
	logic [7:0]            ks_i;
	logic [7:0]            ks_j;
	logic [4:0]            key_len_reg;
	logic [63:0]           key_lo_reg;
	logic [63:0]           key_hi_reg;

	cipher_exp_t           cipher_q [$];
	stim_row_t             directed_rows [$];

	int                    mismatch_count = 0;
	int                    results_seen = 0;
	int                    words_sent = 0;
	int                    rekeys = 0;
	int                    reg_writes = 0;
	int                    cycle_count = 0;
	int                    idle_pct = 20;
	bit                    hold_off_req = 1'b0;

	rc4_stream_cipher_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.start_of_message (start_of_message),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.data_out         (data_out),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// register write as the block sees it, unknown indexes are dropped
	function automatic void apply_key_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		case (idx)
			CFG_KEY_LENGTH: key_len_reg = val[4:0];
			CFG_KEY_LOW:    key_lo_reg = val;
			CFG_KEY_HIGH:   key_hi_reg = val;
			default: ;
		endcase
	endfunction

	// 256-round key schedule over the effective key, clears both indices
	function automatic void schedule_key();
		int          n;
		int          a;
		logic [7:0]  b;
		logic [7:0]  t;
		logic [127:0] key;
		n = key_len_reg;
		if (n < 1)
			n = 1;
		if (n > MAX_KEY_BYTES)
			n = MAX_KEY_BYTES;
		key = {key_hi_reg, key_lo_reg};
		for (a = 0; a < PERM_SIZE; a++)
			sbox[a] = a[7:0];
		b = 8'd0;
		for (a = 0; a < PERM_SIZE; a++) begin
			b = b + sbox[a] + key[8 * (a % n) +: 8];
			t = sbox[a];
			sbox[a] = sbox[b];
			sbox[b] = t;
		end
		ks_i = 8'd0;
		ks_j = 8'd0;
	endfunction

	// one keystream step applied to a data word
	function automatic logic [7:0] next_cipher_byte(logic [7:0] d, logic som);
		logic [7:0] t;
		logic [7:0] s;
		if (som)
			schedule_key();
		ks_i = ks_i + 8'd1;
		ks_j = ks_j + sbox[ks_i];
		t = sbox[ks_i];
		sbox[ks_i] = sbox[ks_j];
		sbox[ks_j] = t;
		s = sbox[ks_i] + sbox[ks_j];
		return d ^ sbox[s];
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_index = idx;
		r.reg_value = val;
		return r;
	endfunction

	function automatic stim_row_t word_row(logic [7:0] d, logic som, logic known,
			logic [7:0] kout);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.din = d;
		r.som = som;
		r.known = known;
		r.known_out = kout;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		// keep the log readable when everything goes wrong
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// offer one data word, optionally after an idle burst, and log its expectation
	task automatic send_word(input logic [7:0] d, input logic som, input logic known,
			input logic [7:0] kout);
		int          gap;
		cipher_exp_t w;
		cfg_valid <= 1'b0;
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		start_of_message <= som;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		w.data_out = next_cipher_byte(d, som);
		if (known)
			w.data_out = kout;
		w.seq = words_sent;
		cipher_q.push_back(w);
		words_sent++;
		if (som)
			rekeys++;
	endtask

	// register write, only once every pending result has come back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		in_valid <= 1'b0;
		if (cipher_q.size() != 0) begin
			cfg_valid <= 1'b0;
			while (cipher_q.size() != 0)
				@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		apply_key_reg(idx, val);
		reg_writes++;
	endtask

	// result side: random stall bursts plus one long hold-off on request
	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		cipher_exp_t w;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (cipher_q.size() == 0) begin
				report_mismatch($sformatf("result %02h with nothing expected", data_out));
			end else begin
				w = cipher_q.pop_front();
				results_seen++;
				if (data_out !== w.data_out)
					report_mismatch($sformatf("word %0d data_out %02h, expected %02h",
						w.seq, data_out, w.data_out));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", cipher_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int          phase;
		int          n_msgs;
		int          m;
		int          k;
		int          len;
		logic [4:0]  klen;
		logic [63:0] val;

		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		start_of_message = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_KEY_LENGTH;
		cfg_data = '0;

		key_len_reg = KEY_LENGTH_RESET;
		key_lo_reg = '0;
		key_hi_reg = '0;
		ks_i = 8'd0;
		ks_j = 8'd0;

		// key "Wiki" under the reset key length, text "pedia"
		directed_rows.push_back(reg_row(CFG_KEY_LOW, 64'h0000_0000_696B_6957));
		directed_rows.push_back(word_row(8'h70, 1'b1, 1'b1, 8'h10));
		directed_rows.push_back(word_row(8'h65, 1'b0, 1'b1, 8'h21));
		directed_rows.push_back(word_row(8'h64, 1'b0, 1'b1, 8'hBF));
		directed_rows.push_back(word_row(8'h69, 1'b0, 1'b1, 8'h04));
		directed_rows.push_back(word_row(8'h61, 1'b0, 1'b1, 8'h20));
		// key "Key", text "Plaintext"
		directed_rows.push_back(reg_row(CFG_KEY_LENGTH, 64'd3));
		directed_rows.push_back(reg_row(CFG_KEY_LOW, 64'h0000_0000_0079_654B));
		directed_rows.push_back(word_row(8'h50, 1'b1, 1'b1, 8'hBB));
		directed_rows.push_back(word_row(8'h6C, 1'b0, 1'b1, 8'hF3));
		directed_rows.push_back(word_row(8'h61, 1'b0, 1'b1, 8'h16));
		directed_rows.push_back(word_row(8'h69, 1'b0, 1'b1, 8'hE8));
		directed_rows.push_back(word_row(8'h6E, 1'b0, 1'b1, 8'hD9));
		directed_rows.push_back(word_row(8'h74, 1'b0, 1'b1, 8'h40));
		directed_rows.push_back(word_row(8'h65, 1'b0, 1'b1, 8'hAF));
		directed_rows.push_back(word_row(8'h78, 1'b0, 1'b1, 8'h0A));
		directed_rows.push_back(word_row(8'h74, 1'b0, 1'b1, 8'hD3));
		// zero key length acts as one byte, all-ones key
		directed_rows.push_back(reg_row(CFG_KEY_LENGTH, 64'd0));
		directed_rows.push_back(reg_row(CFG_KEY_HIGH, '1));
		directed_rows.push_back(reg_row(CFG_KEY_LOW, '1));
		directed_rows.push_back(word_row(8'h00, 1'b1, 1'b0, 8'h00));
		directed_rows.push_back(word_row(8'hFF, 1'b0, 1'b0, 8'h00));
		// oversized key length saturates to the full 16 bytes
		directed_rows.push_back(reg_row(CFG_KEY_LENGTH, 64'd31));
		directed_rows.push_back(reg_row(CFG_KEY_LOW, 64'h0123_4567_89AB_CDEF));
		directed_rows.push_back(reg_row(CFG_KEY_HIGH, 64'hFEDC_BA98_7654_3210));
		directed_rows.push_back(word_row(8'hFF, 1'b1, 1'b0, 8'h00));
		directed_rows.push_back(word_row(8'h00, 1'b0, 1'b0, 8'h00));
		// write to a missing register is dropped
		directed_rows.push_back(reg_row(CFG_UNUSED, '1));
		directed_rows.push_back(reg_row(CFG_KEY_LENGTH, 64'd16));
		directed_rows.push_back(word_row(8'hA5, 1'b1, 1'b0, 8'h00));
		directed_rows.push_back(word_row(8'h5A, 1'b0, 1'b0, 8'h00));
		// back-to-back restarts
		directed_rows.push_back(word_row(8'h00, 1'b1, 1'b0, 8'h00));
		directed_rows.push_back(word_row(8'h80, 1'b1, 1'b0, 8'h00));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_REG)
				write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
			else
				send_word(directed_rows[r].din, directed_rows[r].som,
					directed_rows[r].known, directed_rows[r].known_out);
		end

		// random phases: new settings, then a few messages each
		phase = 0;
		while (words_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: klen = 5'd0;
				1: klen = 5'd1;
				2: klen = 5'd16;
				3: klen = 5'($urandom_range(17, 31));
				default: klen = 5'($urandom_range(1, 16));
			endcase
			val = {$urandom, $urandom};
			val[4:0] = klen;
			write_reg(CFG_KEY_LENGTH, val);
			for (k = 0; k < 2; k++) begin
				if (phase == 0 || $urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 5))
						0: val = '0;
						1: val = '1;
						default: val = {$urandom, $urandom};
					endcase
					write_reg(k == 0 ? CFG_KEY_LOW : CFG_KEY_HIGH, val);
				end
			end
			if ($urandom_range(0, 5) == 0)
				write_reg(CFG_UNUSED, {$urandom, $urandom});

			n_msgs = $urandom_range(2, 6);
			for (m = 0; m < n_msgs && words_sent < ITEM_TARGET; m++) begin
				if (words_sent >= ITEM_TARGET - CALM_ITEMS)
					idle_pct = 0;
				else
					idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
				if (phase == 0 && m == 0)
					len = LONG_MSG;
				else if ($urandom_range(0, 7) == 0)
					len = 0;
				else
					len = $urandom_range(1, 40);
				send_word(8'($urandom), 1'b1, 1'b0, 8'h00);
				for (k = 0; k < len; k++) begin
					// long receiver hold while words keep coming
					if (phase == 0 && m == 0 && k == 3)
						hold_off_req = 1'b1;
					send_word(8'($urandom), $urandom_range(0, 99) == 0, 1'b0, 8'h00);
				end
			end
			phase++;
		end

		// drain
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words with %0d key schedules over %0d phases, %0d register writes",
			words_sent, rekeys, phase, reg_writes);
		$display("%0d results checked, %0d mismatches", results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_engine.sv
rtl/rc4_stream_cipher_top.sv
rtl/rc4_checker.sv
test/tb_rc4_stream_cipher_top.sv
